FILE: src/sktab_pkg.sv
// Shared types and constants of the sorted keyed table.
`timescale 1ns / 1ps
`default_nettype none

package sktab_pkg;

   localparam int KEY_W  = 32;
   localparam int QTY_W  = 32;
   localparam int OP_W   = 2;
   localparam int SLOT_W = 7;
   localparam int ENTRY_W = KEY_W + QTY_W;

   // Input word: operation, key and amount packed without gaps, padded to bytes.
   localparam int REQ_BITS = OP_W + KEY_W + QTY_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   // Result word: status, quantity and slot, padded to bytes.
   localparam int RSP_BITS = 2 + QTY_W + SLOT_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Depth of the queue between the front and the back.
   localparam int QDEPTH = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

   localparam logic signed [QTY_W-1:0] QTY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [QTY_W-1:0] QTY_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_DUP     = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_INSERT,
      KIND_SEARCH,
      KIND_UPDATE,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic signed [KEY_W-1:0]  key;
      logic signed [QTY_W-1:0]  amount;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } queue_head_type;

endpackage

`default_nettype wire

FILE: src/sktab_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sktab_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/sktab_front.sv
// Front end: accepts request words, classifies the operation and queues the work.
`timescale 1ns / 1ps
`default_nettype none

module sktab_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [sktab_pkg::REQ_W-1:0]   req_tdata,
   output      sktab_pkg::queue_head_type     head,
   input  wire logic                          pop
);

   import sktab_pkg::*;

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int FW = $clog2(QDEPTH + 1);

   work_type          slots_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]     fill_ff, fill_in;
   work_type          incoming;
   logic              push;
   logic              take;
   logic [OP_W-1:0]   op;

   assign op = req_tdata[OP_W-1:0];

   always_comb begin
      case (op)
         OP_INSERT: incoming.kind = KIND_INSERT;
         OP_SEARCH: incoming.kind = KIND_SEARCH;
         OP_UPDATE: incoming.kind = KIND_UPDATE;
         default:   incoming.kind = KIND_BAD;
      endcase
      incoming.key    = req_tdata[OP_W +: KEY_W];
      incoming.amount = req_tdata[OP_W + KEY_W +: QTY_W];
   end

   assign req_tready = (fill_ff != FW'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign take       = pop && (fill_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      fill_in = fill_ff + FW'(push) - FW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= incoming;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.work  = slots_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: src/sktab_back.sv
// Back end: binary search, entry shifting and result register over the table RAM.
`timescale 1ns / 1ps
`default_nettype none

module sktab_back #(
   parameter int DEPTH = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sktab_pkg::queue_head_type     head,
   output      logic                          pop,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [sktab_pkg::RSP_W-1:0]   rsp_tdata,
   output      logic [$clog2(DEPTH+1)-1:0]    entry_count
);

   import sktab_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEEK,
      S_CMP,
      S_SH_RD,
      S_SH_WR,
      S_PUT,
      S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   work_type                  work_ff, work_in;
   logic [CW-1:0]             lo_ff, lo_in;
   logic [CW-1:0]             hi_ff, hi_in;
   logic [AW-1:0]             mid_ff, mid_in;
   logic [CW-1:0]             cur_ff, cur_in;
   logic [CW-1:0]             count_ff, count_in;
   status_type                res_status_ff, res_status_in;
   logic signed [QTY_W-1:0]   res_qty_ff, res_qty_in;
   logic [SLOT_W-1:0]         res_slot_ff, res_slot_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [QTY_W-1:0]   rsp_qty_ff, rsp_qty_in;
   logic [SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;

   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [ENTRY_W-1:0]        mem_wdata;
   logic [AW-1:0]             mem_raddr;
   logic [ENTRY_W-1:0]        mem_rdata;

   logic [CW:0]               mid_sum;
   logic [AW-1:0]             mid_calc;
   logic signed [KEY_W-1:0]   rd_key;
   logic signed [QTY_W-1:0]   rd_qty;
   logic [QTY_W:0]            upd_sum;
   logic signed [QTY_W-1:0]   upd_sat;
   logic [SW-1:0]             mid_wide;
   logic [SW-1:0]             lo_wide;
   logic [CW-1:0]             cur_less;

   sktab_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[AW:1];
   assign rd_key   = mem_rdata[QTY_W +: KEY_W];
   assign rd_qty   = mem_rdata[QTY_W-1:0];
   assign mid_wide = SW'(mid_ff);
   assign lo_wide  = SW'(lo_ff);
   assign cur_less = cur_ff - CW'(1);

   // Saturating add of the change to the stored quantity.
   always_comb begin
      upd_sum = {rd_qty[QTY_W-1], rd_qty} + {work_ff.amount[QTY_W-1], work_ff.amount};
      if (upd_sum[QTY_W] != upd_sum[QTY_W-1]) begin
         upd_sat = upd_sum[QTY_W] ? QTY_MIN : QTY_MAX;
      end else begin
         upd_sat = upd_sum[QTY_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_qty_in    = res_qty_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_slot_in   = rsp_slot_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = mid_ff;
      mem_wdata     = {work_ff.key, upd_sat};
      mem_raddr     = mid_calc;

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               work_in = head.work;
               lo_in   = '0;
               hi_in   = count_ff;
               res_qty_in  = '0;
               res_slot_in = '0;
               if (head.work.kind == KIND_BAD) begin
                  res_status_in = ST_MISSING;
                  state_in      = S_DONE;
               end else if (head.work.kind == KIND_INSERT && count_ff == CW'(DEPTH)) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SEEK;
               end
            end
         end
         S_SEEK: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               state_in = S_CMP;
            end else if (work_ff.kind == KIND_INSERT) begin
               // Key is absent; lo is the first slot holding a larger key.
               cur_in   = count_ff;
               state_in = (count_ff > lo_ff) ? S_SH_RD : S_PUT;
            end else begin
               res_status_in = ST_MISSING;
               state_in      = S_DONE;
            end
         end
         S_CMP: begin
            if (rd_key == work_ff.key) begin
               state_in = S_DONE;
               case (work_ff.kind)
                  KIND_SEARCH: begin
                     res_status_in = ST_OK;
                     res_qty_in    = rd_qty;
                     res_slot_in   = mid_wide[SLOT_W-1:0];
                  end
                  KIND_UPDATE: begin
                     mem_we        = 1'b1;
                     res_status_in = ST_OK;
                     res_qty_in    = upd_sat;
                     res_slot_in   = mid_wide[SLOT_W-1:0];
                  end
                  default: begin
                     res_status_in = ST_DUP;
                  end
               endcase
            end else begin
               if (rd_key < work_ff.key) begin
                  lo_in = CW'(mid_ff) + CW'(1);
               end else begin
                  hi_in = CW'(mid_ff);
               end
               state_in = S_SEEK;
            end
         end
         S_SH_RD: begin
            mem_raddr = cur_less[AW-1:0];
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff[AW-1:0];
            mem_wdata = mem_rdata;
            cur_in    = cur_less;
            state_in  = (cur_less > lo_ff) ? S_SH_RD : S_PUT;
         end
         S_PUT: begin
            mem_we        = 1'b1;
            mem_waddr     = lo_ff[AW-1:0];
            mem_wdata     = {work_ff.key, work_ff.amount};
            count_in      = count_ff + CW'(1);
            res_status_in = ST_OK;
            res_qty_in    = work_ff.amount;
            res_slot_in   = lo_wide[SLOT_W-1:0];
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_qty_in    = res_qty_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff       <= work_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_qty_ff    <= res_qty_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {(RSP_W - RSP_BITS)'(0), rsp_slot_ff, rsp_qty_ff, rsp_status_ff};
   assign entry_count = count_ff;

endmodule

`default_nettype wire

FILE: src/sorted_keyed_table_core.sv
// Top level of the sorted keyed table: front end, work queue and table back end.
//
//   Channel  Direction  Handshake            Word
//   req      in         req_tvalid/tready    operation, key, amount
//   rsp      out        rsp_tvalid/tready    status, quantity, slot
//
// A search or update runs a binary search over the stored entries: every probe is one
// read of the table RAM and one compare; an update writes the new quantity back in place.
// An insert moves each larger entry up one slot, with a read and then a write, and
// then writes the new entry into the slot that the move has freed.
// Reset empties the table at once; RAM contents are left as they are, no clearing pass.
// Two requests queue up while the back end works or a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_keyed_table_core #(
   parameter int DEPTH = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   // [1:0] operation, [33:2] part_key, [65:34] amount
   input  wire logic [sktab_pkg::REQ_W-1:0]   req_tdata,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [1:0] status, [33:2] quantity_out, [40:34] slot
   output      logic [sktab_pkg::RSP_W-1:0]   rsp_tdata
);

   import sktab_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   queue_head_type    head;
   logic              pop;
   logic [CW-1:0]     entry_count;

   sktab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .pop        (pop)
   );

   sktab_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .entry_count (entry_count)
   );

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      entry_count <= CW'(DEPTH))
      else $error("entry count above table depth");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (entry_count == $past(entry_count) ||
                         entry_count == $past(entry_count) + CW'(1)))
      else $error("entry count moved by more than one insert");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ST_FULL) |-> entry_count == CW'(DEPTH))
      else $error("table full reported while the table has room");

   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("back end took work from an empty queue");

endmodule

`default_nettype wire
